@@ rtl/core/tkd_pkg.sv @@
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types, key codes and decode helpers for the terminal key decoder.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int unsigned KeyW  = 9;
  localparam int unsigned ColW  = 10;
  localparam int unsigned RowW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_COLUMNS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_ROWS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEXT_LINE_COUNT = 2'd2;

  // Key codes
  localparam logic [KeyW-1:0] KC_ESC   = 9'd27;
  localparam logic [KeyW-1:0] KC_QUIT  = 9'd17;   // Ctrl-Q
  localparam logic [KeyW-1:0] KC_LEFT  = 9'd256;
  localparam logic [KeyW-1:0] KC_RIGHT = 9'd257;
  localparam logic [KeyW-1:0] KC_UP    = 9'd258;
  localparam logic [KeyW-1:0] KC_DOWN  = 9'd259;
  localparam logic [KeyW-1:0] KC_DEL   = 9'd260;
  localparam logic [KeyW-1:0] KC_HOME  = 9'd261;
  localparam logic [KeyW-1:0] KC_END   = 9'd262;
  localparam logic [KeyW-1:0] KC_PGUP  = 9'd263;
  localparam logic [KeyW-1:0] KC_PGDN  = 9'd264;

  // Byte constants
  localparam logic [ByteW-1:0] CH_ESC     = 8'h1b;
  localparam logic [ByteW-1:0] CH_BRACKET = 8'h5b;  // '['
  localparam logic [ByteW-1:0] CH_O       = 8'h4f;  // 'O'
  localparam logic [ByteW-1:0] CH_TILDE   = 8'h7e;  // '~'
  localparam logic [ByteW-1:0] CH_0       = 8'h30;
  localparam logic [ByteW-1:0] CH_9       = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_BRACKET,
    PH_O,
    PH_DIGIT,
    PH_SKIP
  } phase_t;

  // Live configuration handed to the cursor unit
  typedef struct packed {
    logic [ColW-1:0] screen_columns;
    logic [ColW-1:0] screen_rows;
    logic [RowW-1:0] text_line_count;
  } tkd_cfg_t;

  // ESC [ letter
  function automatic logic [KeyW-1:0] bracket_letter(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    case (b)
      8'h41:   k = KC_UP;     // 'A'
      8'h42:   k = KC_DOWN;   // 'B'
      8'h43:   k = KC_RIGHT;  // 'C'
      8'h44:   k = KC_LEFT;   // 'D'
      8'h48:   k = KC_HOME;   // 'H'
      8'h46:   k = KC_END;    // 'F'
      default: k = KC_ESC;
    endcase
    return k;
  endfunction

  // ESC [ digit ~
  function automatic logic [KeyW-1:0] tilde_key(input logic [ByteW-1:0] d);
    logic [KeyW-1:0] k;
    case (d)
      8'h31:   k = KC_HOME;
      8'h33:   k = KC_DEL;
      8'h34:   k = KC_END;
      8'h35:   k = KC_PGUP;
      8'h36:   k = KC_PGDN;
      8'h37:   k = KC_HOME;
      8'h38:   k = KC_END;
      default: k = KC_ESC;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/tkd_cursor.sv @@
// ----------------------------------------------------------------------------
// tkd_cursor
// Saturating cursor move for one decoded key.
// ----------------------------------------------------------------------------
module tkd_cursor (
  input  logic [tkd_pkg::KeyW-1:0] key,
  input  tkd_pkg::tkd_cfg_t        cfg,
  input  logic [tkd_pkg::ColW-1:0] col,
  input  logic [tkd_pkg::RowW-1:0] row,
  output logic [tkd_pkg::ColW-1:0] col_nxt,
  output logic [tkd_pkg::RowW-1:0] row_nxt
);
  import tkd_pkg::*;

  logic [ColW-1:0] right_bound;
  logic [RowW-1:0] rows_ext;
  logic [RowW-1:0] room;

  // Zero columns behaves as a single column
  assign right_bound = (cfg.screen_columns == '0) ? '0 : cfg.screen_columns - 1'b1;
  assign rows_ext    = {{(RowW-ColW){1'b0}}, cfg.screen_rows};
  assign room        = cfg.text_line_count - row;

  always_comb begin
    col_nxt = col;
    row_nxt = row;
    unique case (key)
      KC_LEFT:  if (col != '0) col_nxt = col - 1'b1;
      KC_RIGHT: if (col < right_bound) col_nxt = col + 1'b1;
      KC_UP:    if (row != '0) row_nxt = row - 1'b1;
      KC_DOWN:  if (row < cfg.text_line_count) row_nxt = row + 1'b1;
      KC_PGUP:  row_nxt = (row >= rows_ext) ? row - rows_ext : '0;
      KC_PGDN: begin
        if (row < cfg.text_line_count) begin
          row_nxt = (room > rows_ext) ? row + rows_ext : cfg.text_line_count;
        end
      end
      KC_HOME:  col_nxt = '0;
      KC_END:   col_nxt = right_bound;
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/terminal_key_decoder_cursor_unit.sv @@
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor_unit
// Decodes VT100 key escape sequences from a byte stream and tracks a cursor.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | tdata: byte_value; tuser: func (1 = timeout)
//  out_    | master    | tdata: key_code, cursor_col, cursor_row; tuser: quit
//  cfg_    | slave     | cfg_index selects register, cfg_data holds its value
//
//  One item per cycle while the output is not stalled: an input register
//  feeds the escape decoder and the cursor unit, whose result is registered
//  in the output register. Items that produce no key pass through without
//  needing output space. A stalled output holds the input register; new
//  input is taken while the pending result drains. Reset is synchronous.
// ----------------------------------------------------------------------------
module terminal_key_decoder_cursor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] byte_value
  input  logic                          in_tuser,   // [0] func
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [8:0] key_code,
                                                    // [18:9] cursor_col,
                                                    // [34:19] cursor_row, rest 0
  output logic                          out_tuser,  // [0] quit_flag
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tkd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tkd_pkg::CfgDataW-1:0]  cfg_data
);
  import tkd_pkg::*;

  // Configuration registers
  tkd_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_columns  <= 10'd80;
      cfg_r.screen_rows     <= 10'd24;
      cfg_r.text_line_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCREEN_COLUMNS:  cfg_r.screen_columns  <= cfg_data[ColW-1:0];
        CFG_SCREEN_ROWS:     cfg_r.screen_rows     <= cfg_data[ColW-1:0];
        CFG_TEXT_LINE_COUNT: cfg_r.text_line_count <= cfg_data[RowW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  logic             in_v_r;
  logic             tmo_r;
  logic [ByteW-1:0] byte_r;
  logic             advance;

  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tmo_r  <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  // Escape decoder
  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] digit_r, digit_nxt;
  logic [KeyW-1:0]  key;
  logic             has_key;

  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    key       = {1'b0, byte_r};
    has_key   = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (!tmo_r) begin
        if (byte_r == CH_ESC) begin
          phase_nxt = PH_ESC;
        end else begin
          has_key = 1'b1;
        end
      end
    end else if (tmo_r) begin
      key       = KC_ESC;
      has_key   = 1'b1;
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          if (byte_r == CH_BRACKET)  phase_nxt = PH_BRACKET;
          else if (byte_r == CH_O)   phase_nxt = PH_O;
          else                       phase_nxt = PH_SKIP;
        end
        PH_BRACKET: begin
          if (byte_r >= CH_0 && byte_r <= CH_9) begin
            digit_nxt = byte_r;
            phase_nxt = PH_DIGIT;
          end else begin
            key       = bracket_letter(byte_r);
            has_key   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_O: begin
          key       = (byte_r == 8'h48) ? KC_HOME :
                      (byte_r == 8'h46) ? KC_END  : KC_ESC;
          has_key   = 1'b1;
          phase_nxt = PH_IDLE;
        end
        PH_DIGIT: begin
          key       = (byte_r == CH_TILDE) ? tilde_key(digit_r) : KC_ESC;
          has_key   = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: begin
          // dangling byte after ESC, or unreachable idle
          key       = KC_ESC;
          has_key   = 1'b1;
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Cursor update
  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;

  tkd_cursor u_cursor (
    .key     (key),
    .cfg     (cfg_r),
    .col     (col_r),
    .row     (row_r),
    .col_nxt (col_nxt),
    .row_nxt (row_nxt)
  );

  // Stage moves when the result has somewhere to go, or there is none
  logic out_v_r;
  logic load_out;

  assign advance  = in_v_r && (!has_key || !out_v_r || out_tready);
  assign load_out = advance && has_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      digit_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
      if (has_key) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Output register
  logic [KeyW-1:0] key_out_r;
  logic [ColW-1:0] col_out_r;
  logic [RowW-1:0] row_out_r;
  logic            quit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      key_out_r <= key;
      col_out_r <= col_nxt;
      row_out_r <= row_nxt;
      quit_r    <= (key == KC_QUIT);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, row_out_r, col_out_r, key_out_r};
  assign out_tuser  = quit_r;

endmodule
